// ===== rtl/core/afm_pkg.sv =====
package afm_pkg;

  localparam int TABLE_BITS = 10;
  localparam int QUARTER_N = 1 << TABLE_BITS;
  localparam int TAB_ADDR_W = TABLE_BITS + 1;

  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  localparam int IN_DATA_W = 176;
  localparam int OUT_DATA_W = 128;

  typedef logic [14:0] sine_tab_t [0:QUARTER_N];

  typedef struct packed {
    logic [TAB_ADDR_W-1:0] addr;
    logic                  neg;
  } tab_lookup_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pivot_x;
    logic signed [23:0] pivot_y;
  } geom_t;

  typedef struct packed {
    geom_t              geom;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic        [15:0] skew_x;
    logic        [15:0] skew_y;
    logic        [15:0] angle;
  } xform_t;

  typedef struct packed {
    geom_t              geom;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] trig_a;
    logic signed [15:0] trig_b;
    logic signed [15:0] trig_c;
    logic signed [15:0] trig_d;
  } trig_t;

  typedef struct packed {
    geom_t              geom;
    logic signed [15:0] mat_a;
    logic signed [15:0] mat_b;
    logic signed [15:0] mat_c;
    logic signed [15:0] mat_d;
  } lin_t;

  typedef struct packed {
    logic signed [15:0] mat_a;
    logic signed [15:0] mat_b;
    logic signed [15:0] mat_c;
    logic signed [15:0] mat_d;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
  } result_t;

  // Restoring long division; it is only evaluated while the sine table is elaborated.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    int          i;
    q = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine table, round(32767*sin), built from a Taylor series at elaboration.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t    tab;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  n;
    logic [63:0]  scaled;
    logic [127:0] prod;
    logic         sub;
    int           k;
    for (k = 0; k <= QUARTER_N; k++) begin
      x = (HALF_PI_Q62 >> TABLE_BITS) * 64'(k)
        + (((HALF_PI_Q62 & 64'(QUARTER_N - 1)) * 64'(k)) >> TABLE_BITS);
      prod = {64'd0, x} * {64'd0, x};
      x2 = prod[125:62];
      term = x;
      sum = x;
      n = 64'd1;
      sub = 1'b1;
      while (term != 64'd0 && n < 64'd60) begin
        prod = {64'd0, term} * {64'd0, x2};
        term = div_u64(prod[125:62], (n + 64'd1) * (n + 64'd2));
        n = n + 64'd2;
        sum = sub ? sum - term : sum + term;
        sub = !sub;
      end
      scaled = ((sum >> 16) * 64'd32767 + (64'd1 << 45)) >> 46;
      tab[k] = scaled[14:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  function automatic tab_lookup_t tab_lookup(input logic [15:0] ang, input logic flip);
    tab_lookup_t          lk;
    logic [TABLE_BITS-1:0] idx;
    idx = ang[13 -: TABLE_BITS];
    lk.addr = ang[14] ? (TAB_ADDR_W'(QUARTER_N) - {1'b0, idx}) : {1'b0, idx};
    lk.neg = ang[15] ^ flip;
    return lk;
  endfunction

  function automatic logic signed [15:0] tab_value(input tab_lookup_t lk);
    logic [15:0] e;
    e = {1'b0, SINE_TAB[lk.addr]};
    return lk.neg ? $signed(16'd0 - e) : $signed(e);
  endfunction

  // Q1.15 by Q8.8 product back to Q8.8, rounded half up and saturated.
  function automatic logic signed [15:0] round_sat_lin(input logic signed [31:0] p);
    logic signed [31:0] t;
    logic signed [16:0] r;
    t = p + 32'sd16384;
    r = t[31:15];
    if (r[16] != r[15]) begin
      return r[16] ? 16'sh8000 : 16'sh7fff;
    end
    return r[15:0];
  endfunction

  // Q.16 translation back to Q24.8, rounded half up and saturated.
  function automatic logic signed [31:0] round_sat_trans(input logic signed [41:0] s);
    logic signed [41:0] t;
    logic signed [33:0] r;
    t = s + 42'sd128;
    r = t[41:8];
    if (r[33:31] != 3'b000 && r[33:31] != 3'b111) begin
      return r[33] ? 32'sh80000000 : 32'sh7fffffff;
    end
    return r[31:0];
  endfunction

endpackage

// ===== rtl/core/afm_trig.sv =====
module afm_trig (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  afm_pkg::xform_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output afm_pkg::trig_t  out_data
);

  typedef struct packed {
    afm_pkg::geom_t       geom;
    logic signed [15:0]   scale_x;
    logic signed [15:0]   scale_y;
    afm_pkg::tab_lookup_t lk_a;
    afm_pkg::tab_lookup_t lk_b;
    afm_pkg::tab_lookup_t lk_c;
    afm_pkg::tab_lookup_t lk_d;
  } lookup_stage_t;

  logic           v1;
  logic           v2;
  logic           rdy1;
  logic           rdy2;
  lookup_stage_t  s1;
  lookup_stage_t  s1_next;
  afm_pkg::trig_t s2;
  afm_pkg::trig_t s2_next;
  logic [15:0]    ang1;
  logic [15:0]    ang2;

  assign rdy2 = !v2 || out_ready;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v2;
  assign out_data = s2;

  always_comb begin
    ang1 = in_data.angle + in_data.skew_y;
    ang2 = in_data.angle - in_data.skew_x;
    s1_next.geom = in_data.geom;
    s1_next.scale_x = in_data.scale_x;
    s1_next.scale_y = in_data.scale_y;
    s1_next.lk_a = afm_pkg::tab_lookup(ang1 + afm_pkg::QUARTER_TURN, 1'b0);
    s1_next.lk_b = afm_pkg::tab_lookup(ang1, 1'b0);
    s1_next.lk_c = afm_pkg::tab_lookup(ang2, 1'b1);
    s1_next.lk_d = afm_pkg::tab_lookup(ang2 + afm_pkg::QUARTER_TURN, 1'b0);
  end

  always_comb begin
    s2_next.geom = s1.geom;
    s2_next.scale_x = s1.scale_x;
    s2_next.scale_y = s1.scale_y;
    s2_next.trig_a = afm_pkg::tab_value(s1.lk_a);
    s2_next.trig_b = afm_pkg::tab_value(s1.lk_b);
    s2_next.trig_c = afm_pkg::tab_value(s1.lk_c);
    s2_next.trig_d = afm_pkg::tab_value(s1.lk_d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1 <= s1_next;
    if (rdy2 && v1) s2 <= s2_next;
  end

  assert property (@(posedge clk) disable iff (rst)
    v2 |-> (s2.trig_a != 16'sh8000 && s2.trig_b != 16'sh8000 &&
            s2.trig_c != 16'sh8000 && s2.trig_d != 16'sh8000))
    else $error("Table value outside the Q1.15 range.");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("Accepted transfer did not reach the first stage.");

endmodule

// ===== rtl/core/afm_lin.sv =====
module afm_lin (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  afm_pkg::trig_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output afm_pkg::lin_t  out_data
);

  typedef struct packed {
    afm_pkg::geom_t     geom;
    logic signed [31:0] prod_a;
    logic signed [31:0] prod_b;
    logic signed [31:0] prod_c;
    logic signed [31:0] prod_d;
  } prod_stage_t;

  logic          v3;
  logic          v4;
  logic          rdy3;
  logic          rdy4;
  prod_stage_t   s3;
  prod_stage_t   s3_next;
  afm_pkg::lin_t s4;
  afm_pkg::lin_t s4_next;

  assign rdy4 = !v4 || out_ready;
  assign rdy3 = !v3 || rdy4;
  assign in_ready = rdy3;
  assign out_valid = v4;
  assign out_data = s4;

  always_comb begin
    s3_next.geom = in_data.geom;
    s3_next.prod_a = $signed(in_data.trig_a) * $signed(in_data.scale_x);
    s3_next.prod_b = $signed(in_data.trig_b) * $signed(in_data.scale_x);
    s3_next.prod_c = $signed(in_data.trig_c) * $signed(in_data.scale_y);
    s3_next.prod_d = $signed(in_data.trig_d) * $signed(in_data.scale_y);
  end

  always_comb begin
    s4_next.geom = s3.geom;
    s4_next.mat_a = afm_pkg::round_sat_lin(s3.prod_a);
    s4_next.mat_b = afm_pkg::round_sat_lin(s3.prod_b);
    s4_next.mat_c = afm_pkg::round_sat_lin(s3.prod_c);
    s4_next.mat_d = afm_pkg::round_sat_lin(s3.prod_d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy3) v3 <= in_valid;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) s3 <= s3_next;
    if (rdy4 && v3) s4 <= s4_next;
  end

endmodule

// ===== rtl/core/afm_trans.sv =====
module afm_trans (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  afm_pkg::lin_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output afm_pkg::result_t out_data
);

  typedef struct packed {
    logic signed [15:0] mat_a;
    logic signed [15:0] mat_b;
    logic signed [15:0] mat_c;
    logic signed [15:0] mat_d;
    logic signed [32:0] base_x;
    logic signed [32:0] base_y;
    logic signed [39:0] ox_a;
    logic signed [39:0] oy_c;
    logic signed [39:0] ox_b;
    logic signed [39:0] oy_d;
  } mul_stage_t;

  typedef struct packed {
    logic signed [15:0] mat_a;
    logic signed [15:0] mat_b;
    logic signed [15:0] mat_c;
    logic signed [15:0] mat_d;
    logic signed [41:0] sum_x;
    logic signed [41:0] sum_y;
  } sum_stage_t;

  logic               v5;
  logic               v6;
  logic               v7;
  logic               rdy5;
  logic               rdy6;
  logic               rdy7;
  mul_stage_t         s5;
  mul_stage_t         s5_next;
  sum_stage_t         s6;
  sum_stage_t         s6_next;
  afm_pkg::result_t   s7;
  afm_pkg::result_t   s7_next;
  logic signed [24:0] psum_x;
  logic signed [24:0] psum_y;

  assign rdy7 = !v7 || out_ready;
  assign rdy6 = !v6 || rdy7;
  assign rdy5 = !v5 || rdy6;
  assign in_ready = rdy5;
  assign out_valid = v7;
  assign out_data = s7;

  always_comb begin
    psum_x = 25'(in_data.geom.pos_x) + 25'(in_data.geom.pivot_x);
    psum_y = 25'(in_data.geom.pos_y) + 25'(in_data.geom.pivot_y);
    s5_next.mat_a = in_data.mat_a;
    s5_next.mat_b = in_data.mat_b;
    s5_next.mat_c = in_data.mat_c;
    s5_next.mat_d = in_data.mat_d;
    s5_next.base_x = $signed({psum_x, 8'd0});
    s5_next.base_y = $signed({psum_y, 8'd0});
    s5_next.ox_a = $signed(in_data.geom.pivot_x) * $signed(in_data.mat_a);
    s5_next.oy_c = $signed(in_data.geom.pivot_y) * $signed(in_data.mat_c);
    s5_next.ox_b = $signed(in_data.geom.pivot_x) * $signed(in_data.mat_b);
    s5_next.oy_d = $signed(in_data.geom.pivot_y) * $signed(in_data.mat_d);
  end

  always_comb begin
    s6_next.mat_a = s5.mat_a;
    s6_next.mat_b = s5.mat_b;
    s6_next.mat_c = s5.mat_c;
    s6_next.mat_d = s5.mat_d;
    s6_next.sum_x = 42'(s5.base_x) - 42'(s5.ox_a) - 42'(s5.oy_c);
    s6_next.sum_y = 42'(s5.base_y) - 42'(s5.ox_b) - 42'(s5.oy_d);
  end

  always_comb begin
    s7_next.mat_a = s6.mat_a;
    s7_next.mat_b = s6.mat_b;
    s7_next.mat_c = s6.mat_c;
    s7_next.mat_d = s6.mat_d;
    s7_next.trans_x = afm_pkg::round_sat_trans(s6.sum_x);
    s7_next.trans_y = afm_pkg::round_sat_trans(s6.sum_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy5) v5 <= in_valid;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && in_valid) s5 <= s5_next;
    if (rdy6 && v5) s6 <= s6_next;
    if (rdy7 && v6) s7 <= s7_next;
  end

endmodule

// ===== rtl/core/affine_matrix_from_transform_core.sv =====
// Builds the 2x3 local affine matrix of one sprite transform per transfer.
// The slave channel takes position, pivot origin, Q8.8 scale, two skew angles and a
// rotation angle in binary angle units; the master channel returns the four Q8.8
// linear terms and the two Q24.8 translations, one result per input transfer.
// The block is a seven-stage pipeline: angle sums and table addressing, sine table
// read, trig-by-scale multiply, rounding of the linear terms, origin multiplies,
// translation sum, and rounding into the output register.
// Throughput is one transfer per cycle while m_axis_tready stays high, since every
// stage takes a new item in each cycle in which it can pass its own one on.
// Each stage holds its item while the next stage is full and stalled, so a stall on the
// master side fills empty stages first; s_axis_tready falls only when every stage
// holds an item and m_axis_tready is low. Nothing is lost or repeated.
// The synchronous reset empties all stages; the sine table is constant, so the
// block accepts a transfer as soon as reset is released.
module affine_matrix_from_transform_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x, pos_y, pivot_x, pivot_y, scale_x, scale_y, skew_x, skew_y, angle
  input  logic [afm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // mat_a, mat_b, mat_c, mat_d, trans_x, trans_y
  output logic [afm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  afm_pkg::xform_t  xform;
  afm_pkg::trig_t   trig;
  afm_pkg::lin_t    lin;
  afm_pkg::result_t result;
  logic             trig_valid;
  logic             trig_ready;
  logic             lin_valid;
  logic             lin_ready;

  always_comb begin
    xform.geom.pos_x = s_axis_tdata[23:0];
    xform.geom.pos_y = s_axis_tdata[47:24];
    xform.geom.pivot_x = s_axis_tdata[71:48];
    xform.geom.pivot_y = s_axis_tdata[95:72];
    xform.scale_x = s_axis_tdata[111:96];
    xform.scale_y = s_axis_tdata[127:112];
    xform.skew_x = s_axis_tdata[143:128];
    xform.skew_y = s_axis_tdata[159:144];
    xform.angle = s_axis_tdata[175:160];
  end

  assign m_axis_tdata = {result.trans_y, result.trans_x, result.mat_d,
                         result.mat_c, result.mat_b, result.mat_a};

  afm_trig u_trig (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (xform),
    .out_valid (trig_valid),
    .out_ready (trig_ready),
    .out_data  (trig)
  );

  afm_lin u_lin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (trig_valid),
    .in_ready  (trig_ready),
    .in_data   (trig),
    .out_valid (lin_valid),
    .out_ready (lin_ready),
    .out_data  (lin)
  );

  afm_trans u_trans (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lin_valid),
    .in_ready  (lin_ready),
    .in_data   (lin),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (result)
  );

  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Result valid right after reset.");

  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("Input stalled while the output side was free.");

  assert property (@(posedge clk) disable iff (rst)
    !lin_ready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("Back pressure inside the pipeline without a full output stage.");

endmodule

// ===== test/tb_affine_matrix_from_transform_core.sv =====
`timescale 1ns / 100ps

module tb_affine_matrix_from_transform_core;

  localparam int LUT_BITS = afm_pkg::TABLE_BITS;
  localparam int LUT_TOP = 1 << LUT_BITS;
  localparam logic [63:0] HALF_PI = afm_pkg::HALF_PI_Q62;
  localparam logic [15:0] QUARTER = afm_pkg::QUARTER_TURN;
  localparam longint I32_MIN = -(longint'(1) << 31);
  localparam longint I32_MAX = (longint'(1) << 31) - 1;
  localparam int RANDOM_ITEMS = 1230;
  localparam int CALM_TAIL = 200;
  localparam int SETTLE_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pivot_x;
    logic signed [23:0] pivot_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic        [15:0] skew_x;
    logic        [15:0] skew_y;
    logic        [15:0] angle;
  } sprite_xform_t;

  typedef struct packed {
    logic signed [15:0] mat_a;
    logic signed [15:0] mat_b;
    logic signed [15:0] mat_c;
    logic signed [15:0] mat_d;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
  } local_matrix_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  sprite_xform_t xforms_todo[$];
  local_matrix_t matrices_due[$];
  sprite_xform_t on_bus = '0;
  int            quarter_sine [0:LUT_TOP];
  bit            in_took = 1'b0;
  int            xforms_taken = 0;
  int            pause_at = 25;
  int            gap_left = 0;
  int            stall_left = 0;
  int            quiet_cycles = 0;
  int            fails = 0;

  affine_matrix_from_transform_core DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Sine of the quarter wave by its Taylor series in Q2.62, scaled to 32767.
  function automatic void fill_quarter_sine();
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] n;
    logic [63:0] scaled;
    logic        subtract;
    int          k;
    for (k = 0; k <= LUT_TOP; k++) begin
      x = (HALF_PI >> LUT_BITS) * 64'(k)
        + (((HALF_PI & 64'(LUT_TOP - 1)) * 64'(k)) >> LUT_BITS);
      x2 = q62_mul(x, x);
      term = x;
      acc = x;
      n = 64'd1;
      subtract = 1'b1;
      while (term != 64'd0 && n < 64'd60) begin
        term = q62_mul(term, x2) / ((n + 64'd1) * (n + 64'd2));
        n = n + 64'd2;
        acc = subtract ? acc - term : acc + term;
        subtract = !subtract;
      end
      scaled = ((acc >> 16) * 64'd32767 + (64'd1 << 45)) >> 46;
      quarter_sine[k] = int'(scaled);
    end
  endfunction

  function automatic longint sine_q15(logic [15:0] a);
    logic [LUT_BITS-1:0] idx;
    longint              v;
    idx = a[13 -: LUT_BITS];
    v = a[14] ? longint'(quarter_sine[LUT_TOP - int'(idx)]) : longint'(quarter_sine[idx]);
    return a[15] ? -v : v;
  endfunction

  function automatic longint round_half_up(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic local_matrix_t predict_matrix(sprite_xform_t t);
    logic [15:0]   a1;
    logic [15:0]   a2;
    longint        px, py, ox, oy, sx, sy;
    longint        ma, mb, mc, md, tx, ty;
    local_matrix_t r;
    px = longint'($signed(t.pos_x));
    py = longint'($signed(t.pos_y));
    ox = longint'($signed(t.pivot_x));
    oy = longint'($signed(t.pivot_y));
    sx = longint'($signed(t.scale_x));
    sy = longint'($signed(t.scale_y));
    a1 = t.angle + t.skew_y;
    a2 = t.angle - t.skew_x;
    ma = clamp(round_half_up(sine_q15(a1 + QUARTER) * sx, 15), -32768, 32767);
    mb = clamp(round_half_up(sine_q15(a1) * sx, 15), -32768, 32767);
    mc = clamp(round_half_up(-(sine_q15(a2) * sy), 15), -32768, 32767);
    md = clamp(round_half_up(sine_q15(a2 + QUARTER) * sy, 15), -32768, 32767);
    tx = (px + ox) * 256 - ox * ma - oy * mc;
    ty = (py + oy) * 256 - ox * mb - oy * md;
    r.mat_a = 16'(ma);
    r.mat_b = 16'(mb);
    r.mat_c = 16'(mc);
    r.mat_d = 16'(md);
    r.trans_x = 32'(clamp(round_half_up(tx, 8), I32_MIN, I32_MAX));
    r.trans_y = 32'(clamp(round_half_up(ty, 8), I32_MIN, I32_MAX));
    return r;
  endfunction

  function automatic void add_xform(int px, int py, int ox, int oy, int sx, int sy,
                                    int kx, int ky, int ang);
    sprite_xform_t t;
    t.pos_x = 24'(px);
    t.pos_y = 24'(py);
    t.pivot_x = 24'(ox);
    t.pivot_y = 24'(oy);
    t.scale_x = 16'(sx);
    t.scale_y = 16'(sy);
    t.skew_x = 16'(kx);
    t.skew_y = 16'(ky);
    t.angle = 16'(ang);
    xforms_todo.push_back(t);
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(negedge clk) begin
    sprite_xform_t nxt;
    if (!rst && (!s_axis_tvalid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (xforms_taken == pause_at) begin
        // Hold off until the pipeline has handed back every matrix.
        if (matrices_due.size() == 0) begin
          pause_at = (pause_at == 25) ? 700 : -1;
        end
        s_axis_tvalid <= 1'b0;
      end else if (xforms_todo.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = xforms_todo.pop_front();
        on_bus <= nxt;
        s_axis_tdata <= {nxt.angle, nxt.skew_y, nxt.skew_x, nxt.scale_y, nxt.scale_x,
                         nxt.pivot_y, nxt.pivot_x, nxt.pos_y, nxt.pos_x};
        s_axis_tvalid <= 1'b1;
        if (xforms_todo.size() > CALM_TAIL && (xforms_taken / 150) % 3 != 2
            && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 16);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (xforms_todo.size() > CALM_TAIL && (xforms_taken / 150) % 3 != 1
          && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
    end
  end

  always @(posedge clk) begin
    local_matrix_t want;
    in_took <= s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        matrices_due.push_back(predict_matrix(on_bus));
        xforms_taken <= xforms_taken + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (matrices_due.size() == 0) begin
          $error("unexpected result transfer: %h", m_axis_tdata);
          fails++;
        end else begin
          want = matrices_due.pop_front();
          compare_field("mat_a", $signed(want.mat_a), $signed(m_axis_tdata[15:0]));
          compare_field("mat_b", $signed(want.mat_b), $signed(m_axis_tdata[31:16]));
          compare_field("mat_c", $signed(want.mat_c), $signed(m_axis_tdata[47:32]));
          compare_field("mat_d", $signed(want.mat_d), $signed(m_axis_tdata[63:48]));
          compare_field("trans_x", $signed(want.trans_x), $signed(m_axis_tdata[95:64]));
          compare_field("trans_y", $signed(want.trans_y), $signed(m_axis_tdata[127:96]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_affine_matrix_from_transform_core failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sprite_xform_t t;
    int            k;
    fill_quarter_sine();

    add_xform(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_xform(4096, -2560, 300, 700, 256, 256, 0, 0, 0);
    add_xform(8388607, 8388607, 8388607, 8388607, 32767, 32767, 65535, 65535, 65535);
    add_xform(-8388608, -8388608, -8388608, -8388608, -32768, -32768, 0, 0, 0);
    add_xform(1000, 2000, 1000, -1000, 256, 256, 0, 0, 16384);
    add_xform(1000, 2000, 1000, -1000, 256, 256, 0, 0, 32768);
    add_xform(1000, 2000, 1000, -1000, 256, 256, 0, 0, 49152);
    add_xform(1000, 2000, 1000, -1000, 256, 256, 0, 0, 65535);
    add_xform(1000, 2000, 1000, -1000, 256, 256, 0, 0, 1);
    add_xform(-500, 500, 2560, 2560, 512, -384, 0, 0, 16383);
    add_xform(-500, 500, 2560, 2560, 512, -384, 0, 0, 16400);
    // Skew sums that wrap past a full turn in both directions.
    add_xform(0, 0, 256, 256, 256, 256, 0, 10000, 60000);
    add_xform(0, 0, 256, 256, 256, 256, 5000, 0, 100);
    add_xform(0, 0, 256, 256, 256, 256, 40000, 30000, 32768);
    // Translations driven into both saturation limits.
    add_xform(8388607, 0, 8388607, 8388607, -32768, -32768, 16384, 0, 0);
    add_xform(-8388608, 0, -8388608, -8388608, -32768, -32768, 16384, 0, 0);
    add_xform(0, 8388607, 8388607, 8388607, -32768, -32768, 0, 16384, 0);
    add_xform(0, -8388608, -8388608, -8388608, -32768, -32768, 0, 16384, 0);
    // Products that sit exactly halfway between two results.
    add_xform(0, 0, 0, 0, 16384, -16384, 0, 0, 0);
    add_xform(0, 0, 0, 0, -16384, 16384, 0, 0, 0);
    add_xform(0, 0, 128, 0, 257, 256, 0, 0, 0);
    add_xform(0, 0, -128, 128, 257, -257, 0, 0, 0);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      t.pos_x = 24'($urandom);
      t.pos_y = 24'($urandom);
      t.pivot_x = 24'($urandom);
      t.pivot_y = 24'($urandom);
      t.scale_x = 16'($urandom);
      t.scale_y = 16'($urandom);
      t.skew_x = 16'($urandom);
      t.skew_y = 16'($urandom);
      t.angle = 16'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        t.scale_x = 16'(int'($urandom_range(0, 1023)) - 512);
        t.scale_y = 16'(int'($urandom_range(0, 1023)) - 512);
        t.pivot_x = 24'(int'($urandom_range(0, 65535)) - 32768);
        t.pivot_y = 24'(int'($urandom_range(0, 65535)) - 32768);
        if ($urandom_range(0, 1) == 0) begin
          t.skew_x = 16'd0;
          t.skew_y = 16'd0;
        end
      end
      xforms_todo.push_back(t);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (xforms_todo.size() != 0 || matrices_due.size() != 0 || s_axis_tvalid) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("tb_affine_matrix_from_transform_core passed");
    end else begin
      $display("tb_affine_matrix_from_transform_core failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/afm_pkg.sv
rtl/core/afm_trig.sv
rtl/core/afm_lin.sv
rtl/core/afm_trans.sv
rtl/core/affine_matrix_from_transform_core.sv
test/tb_affine_matrix_from_transform_core.sv
